/* src/fee_pkg.sv */
// Package for the flash EEPROM emulation store: geometry constants, command and
// status codes, item structs and the memory port structs.
// No dependencies; every other file of the block uses it by scoped names.
`default_nettype none

package fee_pkg;

    // Store geometry.
    localparam int NUM_PAGES        = 2;
    localparam int ENTRIES_PER_PAGE = 64;
    localparam int DATA_BITS        = 32;

    localparam int TOTAL_SLOTS = NUM_PAGES * ENTRIES_PER_PAGE;
    localparam int PAGE_W      = $clog2(NUM_PAGES);
    localparam int SLOT_W      = $clog2(ENTRIES_PER_PAGE);
    localparam int CNT_W       = $clog2(ENTRIES_PER_PAGE + 1);
    localparam int ADDR_W      = $clog2(TOTAL_SLOTS);
    localparam int VAL_W       = (DATA_BITS < 32) ? DATA_BITS : 32;

    localparam int KEY_W       = 32;
    localparam int KEY_BYTES_W = 3;

    localparam logic [KEY_BYTES_W-1:0] KEY_BYTES_RESET = 3'd2;
    localparam logic [KEY_BYTES_W-1:0] KEY_BYTES_ONE   = 3'd1;
    localparam logic [KEY_BYTES_W-1:0] KEY_BYTES_TWO   = 3'd2;

    localparam logic [KEY_W-1:0] MASK_8  = 32'h0000_00FF;
    localparam logic [KEY_W-1:0] MASK_16 = 32'h0000_FFFF;
    localparam logic [KEY_W-1:0] MASK_32 = 32'hFFFF_FFFF;

    // Commands.
    localparam logic [1:0] CMD_WRITE = 2'd0;
    localparam logic [1:0] CMD_READ  = 2'd1;
    localparam logic [1:0] CMD_ERASE = 2'd2;

    // Result status codes.
    localparam logic [1:0] ST_OK         = 2'd0;
    localparam logic [1:0] ST_NOT_FOUND  = 2'd1;
    localparam logic [1:0] ST_FULL       = 2'd2;
    localparam logic [1:0] ST_ERASED_KEY = 2'd3;

    typedef struct packed {
        logic [1:0]  cmd;
        logic [31:0] key;
        logic [31:0] write_data;
    } t_in_item;

    typedef struct packed {
        logic [1:0]  status;
        logic [31:0] read_data;
    } t_out_item;

    typedef struct packed {
        logic              en;
        logic [ADDR_W-1:0] addr;
        logic [KEY_W-1:0]  key;
        logic [VAL_W-1:0]  val;
    } t_mem_wr;

    typedef struct packed {
        logic [KEY_W-1:0] key;
        logic [VAL_W-1:0] val;
    } t_mem_rd;

    // Key mask selected by the key width register.
    function automatic logic [KEY_W-1:0] key_mask(input logic [KEY_BYTES_W-1:0] kb);
        logic [KEY_W-1:0] m;
        case (kb)
            KEY_BYTES_ONE: m = MASK_8;
            KEY_BYTES_TWO: m = MASK_16;
            default:       m = MASK_32;
        endcase
        return m;
    endfunction

    // Flat slot address of a slot within a page.
    function automatic logic [ADDR_W-1:0] slot_addr(input logic [PAGE_W-1:0] pg,
                                                    input logic [SLOT_W-1:0] slot);
        return ADDR_W'(pg) * ADDR_W'(ENTRIES_PER_PAGE) + ADDR_W'(slot);
    endfunction

endpackage

`default_nettype wire

/* src/fee_slot_mem.sv */
// Slot memory of the flash EEPROM emulation store: key and value arrays with one
// write port and one registered read port. Depends on fee_pkg.
`default_nettype none

module fee_slot_mem (
    input  wire logic                        i_clk,
    input  wire fee_pkg::t_mem_wr            i_wr,
    input  wire logic [fee_pkg::ADDR_W-1:0]  i_raddr,
    output fee_pkg::t_mem_rd                 o_rd
);

    logic [fee_pkg::KEY_W-1:0] r_key_mem [fee_pkg::TOTAL_SLOTS];
    logic [fee_pkg::VAL_W-1:0] r_val_mem [fee_pkg::TOTAL_SLOTS];

    // Keys and values share the address, so an entry moves as a whole in one access.
    always_ff @(posedge i_clk) begin
        if (i_wr.en) begin
            r_key_mem[i_wr.addr] <= i_wr.key;
            r_val_mem[i_wr.addr] <= i_wr.val;
        end
        o_rd.key <= r_key_mem[i_raddr];
        o_rd.val <= r_val_mem[i_raddr];
    end

endmodule

`default_nettype wire

/* src/flash_eeprom_emulation_store.sv */
// Flash EEPROM emulation store, log structured over rotating pages: top level.
// A write into a full page first compacts it. A new item is taken only once the last
// result has gone to the output register.
// Reset: page 0 active, empty, key width 2 bytes; the slot memory is not cleared.
// Depends on fee_pkg and fee_slot_mem.
`default_nettype none

module flash_eeprom_emulation_store (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_in_valid,
    output logic                                   o_in_ready,
    input  wire fee_pkg::t_in_item                 i_in_item,
    output logic                                   o_out_valid,
    input  wire logic                              i_out_ready,
    output fee_pkg::t_out_item                     o_out_item,
    input  wire logic                              i_cfg_we,
    input  wire logic [fee_pkg::KEY_BYTES_W-1:0]   i_cfg_wdata
);

    // Sequencer states. Every slot access goes through the single memory port pair.
    localparam logic [3:0] S_IDLE    = 4'd0;
    localparam logic [3:0] S_R_ISSUE = 4'd1;  // read: fetch candidate slot
    localparam logic [3:0] S_R_CMP   = 4'd2;  // read: compare its key
    localparam logic [3:0] S_C_SRC   = 4'd3;  // compaction: fetch source entry
    localparam logic [3:0] S_C_LATCH = 4'd4;  // compaction: hold source entry
    localparam logic [3:0] S_C_SCAN  = 4'd5;  // compaction: fetch copied entry or copy
    localparam logic [3:0] S_C_CMP   = 4'd6;  // compaction: duplicate key test
    localparam logic [3:0] S_C_NEXT  = 4'd7;  // compaction: step to next source entry
    localparam logic [3:0] S_APPEND  = 4'd8;  // write entry at the fill position
    localparam logic [3:0] S_DONE    = 4'd9;  // hand the result to the output register

    localparam logic [fee_pkg::CNT_W-1:0] FILL_FULL = fee_pkg::CNT_W'(fee_pkg::ENTRIES_PER_PAGE);
    localparam logic [fee_pkg::CNT_W-1:0] CNT_ONE   = fee_pkg::CNT_W'(1);
    localparam logic [fee_pkg::PAGE_W-1:0] LAST_PAGE = fee_pkg::PAGE_W'(fee_pkg::NUM_PAGES - 1);

    // Control state.
    logic [3:0]                        r_state, n_state;
    logic [fee_pkg::KEY_BYTES_W-1:0]   r_key_bytes;
    logic [fee_pkg::PAGE_W-1:0]        r_page, n_page;
    logic [fee_pkg::CNT_W-1:0]         r_fill, n_fill;
    logic [fee_pkg::CNT_W-1:0]         r_idx, n_idx;        // source position, counts down
    logic [fee_pkg::CNT_W-1:0]         r_copied, n_copied;  // entries copied to the new page
    logic [fee_pkg::CNT_W-1:0]         r_j, n_j;            // duplicate scan position
    logic                              r_out_valid, n_out_valid;

    // Item payload.
    logic [fee_pkg::KEY_W-1:0]         r_key, n_key;
    logic [fee_pkg::VAL_W-1:0]         r_data, n_data;
    logic [fee_pkg::KEY_W-1:0]         r_src_key, n_src_key;
    logic [fee_pkg::VAL_W-1:0]         r_src_val, n_src_val;
    logic [1:0]                        r_status, n_status;
    logic [31:0]                       r_rdata, n_rdata;
    fee_pkg::t_out_item                r_out_item, n_out_item;

    logic [fee_pkg::KEY_W-1:0]         w_mask;
    logic [fee_pkg::KEY_W-1:0]         w_in_key;
    logic [fee_pkg::PAGE_W-1:0]        w_dst_page;
    logic [fee_pkg::SLOT_W-1:0]        w_idx_slot;
    fee_pkg::t_mem_wr                  w_wr;
    logic [fee_pkg::ADDR_W-1:0]        w_raddr;
    fee_pkg::t_mem_rd                  w_rd;

    fee_slot_mem u_mem (
        .i_clk   (i_clk),
        .i_wr    (w_wr),
        .i_raddr (w_raddr),
        .o_rd    (w_rd)
    );

    // The key mask follows the register; the user must change it only while the block is idle (not enforced here).
    assign w_mask     = fee_pkg::key_mask(r_key_bytes);
    assign w_in_key   = i_in_item.key & w_mask;
    assign w_dst_page = (r_page == LAST_PAGE) ? '0 : r_page + fee_pkg::PAGE_W'(1);
    assign w_idx_slot = fee_pkg::SLOT_W'(r_idx - CNT_ONE);

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

    always_comb begin
        n_state     = r_state;
        n_page      = r_page;
        n_fill      = r_fill;
        n_idx       = r_idx;
        n_copied    = r_copied;
        n_j         = r_j;
        n_key       = r_key;
        n_data      = r_data;
        n_src_key   = r_src_key;
        n_src_val   = r_src_val;
        n_status    = r_status;
        n_rdata     = r_rdata;
        n_out_item  = r_out_item;
        n_out_valid = r_out_valid;
        w_wr        = '0;
        w_raddr     = fee_pkg::slot_addr(r_page, w_idx_slot);

        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_key    = w_in_key;
                    n_data   = fee_pkg::VAL_W'(i_in_item.write_data);
                    n_status = fee_pkg::ST_OK;
                    n_rdata  = '0;
                    n_state  = S_DONE;
                    case (i_in_item.cmd)
                        fee_pkg::CMD_WRITE: begin
                            if (w_in_key == w_mask) begin
                                n_status = fee_pkg::ST_ERASED_KEY;
                            end else if (r_fill < FILL_FULL) begin
                                n_state = S_APPEND;
                            end else begin
                                // Page full: compact from the newest entry down.
                                n_idx    = r_fill;
                                n_copied = '0;
                                n_state  = S_C_SRC;
                            end
                        end
                        fee_pkg::CMD_READ: begin
                            if (w_in_key == w_mask) begin
                                n_status = fee_pkg::ST_ERASED_KEY;
                            end else if (r_fill == '0) begin
                                n_status = fee_pkg::ST_NOT_FOUND;
                            end else begin
                                n_idx   = r_fill;
                                n_state = S_R_ISSUE;
                            end
                        end
                        fee_pkg::CMD_ERASE: begin
                            // Slots past the fill count are never read, so erasing
                            // the pages needs no sweep of the memory.
                            n_page = '0;
                            n_fill = '0;
                        end
                        default: begin
                        end
                    endcase
                end
            end

            S_R_ISSUE: begin
                w_raddr = fee_pkg::slot_addr(r_page, w_idx_slot);
                n_state = S_R_CMP;
            end

            S_R_CMP: begin
                if ((w_rd.key & w_mask) == r_key) begin
                    n_status = fee_pkg::ST_OK;
                    n_rdata  = 32'(w_rd.val);
                    n_state  = S_DONE;
                end else if (r_idx == CNT_ONE) begin
                    n_status = fee_pkg::ST_NOT_FOUND;
                    n_state  = S_DONE;
                end else begin
                    n_idx   = r_idx - CNT_ONE;
                    n_state = S_R_ISSUE;
                end
            end

            S_C_SRC: begin
                w_raddr = fee_pkg::slot_addr(r_page, w_idx_slot);
                n_state = S_C_LATCH;
            end

            S_C_LATCH: begin
                n_src_key = w_rd.key;
                n_src_val = w_rd.val;
                n_j       = '0;
                n_state   = S_C_SCAN;
            end

            S_C_SCAN: begin
                if (r_j == r_copied) begin
                    // No newer copy of this key on the new page: append it there.
                    w_wr.en   = 1'b1;
                    w_wr.addr = fee_pkg::slot_addr(w_dst_page, fee_pkg::SLOT_W'(r_copied));
                    w_wr.key  = r_src_key;
                    w_wr.val  = r_src_val;
                    n_copied  = r_copied + CNT_ONE;
                    n_state   = S_C_NEXT;
                end else begin
                    w_raddr = fee_pkg::slot_addr(w_dst_page, fee_pkg::SLOT_W'(r_j));
                    n_state = S_C_CMP;
                end
            end

            S_C_CMP: begin
                if ((w_rd.key & w_mask) == (r_src_key & w_mask)) begin
                    n_state = S_C_NEXT;
                end else begin
                    n_j     = r_j + CNT_ONE;
                    n_state = S_C_SCAN;
                end
            end

            S_C_NEXT: begin
                if (r_idx == CNT_ONE) begin
                    // Compaction finished: the new page becomes active.
                    n_page = w_dst_page;
                    n_fill = r_copied;
                    if (r_copied >= FILL_FULL) begin
                        n_status = fee_pkg::ST_FULL;
                        n_state  = S_DONE;
                    end else begin
                        n_state = S_APPEND;
                    end
                end else begin
                    n_idx   = r_idx - CNT_ONE;
                    n_state = S_C_SRC;
                end
            end

            S_APPEND: begin
                w_wr.en   = 1'b1;
                w_wr.addr = fee_pkg::slot_addr(r_page, fee_pkg::SLOT_W'(r_fill));
                w_wr.key  = r_key;
                w_wr.val  = r_data;
                n_fill    = r_fill + CNT_ONE;
                n_status  = fee_pkg::ST_OK;
                n_state   = S_DONE;
            end

            S_DONE: begin
                // The output register frees up in the same cycle it is taken.
                if (!r_out_valid || i_out_ready) begin
                    n_out_valid          = 1'b1;
                    n_out_item.status    = r_status;
                    n_out_item.read_data = r_rdata;
                    n_state              = S_IDLE;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_key_bytes <= fee_pkg::KEY_BYTES_RESET;
            r_page      <= '0;
            r_fill      <= '0;
            r_idx       <= '0;
            r_copied    <= '0;
            r_j         <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_page      <= n_page;
            r_fill      <= n_fill;
            r_idx       <= n_idx;
            r_copied    <= n_copied;
            r_j         <= n_j;
            r_out_valid <= n_out_valid;
            if (i_cfg_we) begin
                r_key_bytes <= i_cfg_wdata;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_key      <= n_key;
        r_data     <= n_data;
        r_src_key  <= n_src_key;
        r_src_val  <= n_src_val;
        r_status   <= n_status;
        r_rdata    <= n_rdata;
        r_out_item <= n_out_item;
    end

    // The fill count never passes the page size.
    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= FILL_FULL)
        else $error("fill count beyond page size");

    // An accepted item keeps the block busy in the next cycle.
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> !o_in_ready)
        else $error("input ready right after an accepted item");

    // Slots are written only when appending or copying during compaction.
    a_write_states: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_wr.en |-> (r_state == S_APPEND || r_state == S_C_SCAN))
        else $error("slot write outside append or compaction copy");

    // The duplicate scan stays within the copied entries, which stay below a page.
    a_scan_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_C_SCAN || r_state == S_C_CMP) |-> (r_j <= r_copied && r_copied < FILL_FULL))
        else $error("compaction scan out of range");

    // A finished result waits while the output register is still occupied.
    a_done_waits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DONE && r_out_valid && !i_out_ready) |=> (r_state == S_DONE))
        else $error("result dropped while output occupied");

endmodule

`default_nettype wire

/* tb/tb_flash_eeprom_emulation_store.sv */
// Self-checking testbench for the flash EEPROM emulation key/value store.
// Depends on fee_pkg for the item structs and codes and on the block under
// test, flash_eeprom_emulation_store; it needs no other file.

module tb_flash_eeprom_emulation_store;

    // The package names three commands; the fourth code is accepted and ignored.
    localparam logic [1:0] CMD_UNUSED = 2'd3;

    // Data bits the store keeps from a write.
    localparam logic [31:0] DATA_KEEP = (fee_pkg::DATA_BITS >= 32) ? 32'hFFFF_FFFF :
        32'((64'd1 << fee_pkg::DATA_BITS) - 64'd1);

    // Number of settings phases in the random part.
    localparam int NUM_PHASES = 9;

    logic                            i_clk = 1'b0;
    logic                            i_rst_n = 1'b0;
    logic                            i_in_valid = 1'b0;
    logic                            o_in_ready;
    fee_pkg::t_in_item               i_in_item = '0;
    logic                            o_out_valid;
    logic                            i_out_ready = 1'b0;
    fee_pkg::t_out_item              o_out_item;
    logic                            i_cfg_we = 1'b0;
    logic [fee_pkg::KEY_BYTES_W-1:0] i_cfg_wdata = '0;

    flash_eeprom_emulation_store dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_item   (i_in_item),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_item  (o_out_item),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // Items waiting to be offered to the block and responses still owed by it.
    fee_pkg::t_in_item  cmd_backlog [$];
    fee_pkg::t_out_item expected_responses [$];

    // Percent of cycles in which the sender and the receiver hold back.
    int send_idle_pct = 0;
    int recv_idle_pct = 0;

    int failures       = 0;
    int items_accepted = 0;
    int compactions    = 0;
    int status_seen [4] = '{0, 0, 0, 0};

    // Predicted store contents. Only the active page can ever be observed,
    // so the prediction keeps that page alone: its keys as written (already
    // cut to the key width in force at the time), its data and its fill.
    logic [fee_pkg::KEY_BYTES_W-1:0] model_key_bytes = fee_pkg::KEY_BYTES_RESET;
    logic [31:0]                     page_keys [fee_pkg::ENTRIES_PER_PAGE];
    logic [31:0]                     page_vals [fee_pkg::ENTRIES_PER_PAGE];
    int                              page_fill = 0;

    // Stimulus side bookkeeping: the key width currently programmed and the
    // set of distinct keys written since the last erase.
    logic [31:0] gen_mask = fee_pkg::MASK_16;
    bit          live_keys [logic [31:0]];
    int          queued_items = 0;

    // One byte keeps the low byte, two bytes the low half, every other
    // register value the whole key.
    function automatic logic [31:0] key_field_mask(
        input logic [fee_pkg::KEY_BYTES_W-1:0] kb);
        if (kb == fee_pkg::KEY_BYTES_ONE) return fee_pkg::MASK_8;
        if (kb == fee_pkg::KEY_BYTES_TWO) return fee_pkg::MASK_16;
        return fee_pkg::MASK_32;
    endfunction

    // A write into a full page first rewrites it: walking from the newest
    // entry back, the first occurrence of each key under the present width
    // survives, and the survivors are packed in that newest-first order.
    function automatic void compact_active_page();
        logic [31:0] new_keys [fee_pkg::ENTRIES_PER_PAGE];
        logic [31:0] new_vals [fee_pkg::ENTRIES_PER_PAGE];
        logic [31:0] m;
        logic [31:0] k;
        int          kept;
        bit          dup;
        m = key_field_mask(model_key_bytes);
        kept = 0;
        for (int i = page_fill; i > 0; i--) begin
            k = page_keys[i-1] & m;
            dup = 1'b0;
            for (int j = 0; j < kept; j++) begin
                if ((new_keys[j] & m) == k) dup = 1'b1;
            end
            if (!dup) begin
                new_keys[kept] = page_keys[i-1];
                new_vals[kept] = page_vals[i-1];
                kept++;
            end
        end
        for (int i = 0; i < kept; i++) begin
            page_keys[i] = new_keys[i];
            page_vals[i] = new_vals[i];
        end
        page_fill = kept;
        compactions++;
    endfunction

    // Works out the response to one accepted item and advances the
    // predicted store state.
    function automatic fee_pkg::t_out_item predict_store_response(
        input fee_pkg::t_in_item it);
        fee_pkg::t_out_item res;
        logic [31:0]        m;
        logic [31:0]        k;
        logic [31:0]        d;
        bit                 found;
        m = key_field_mask(model_key_bytes);
        k = it.key & m;
        d = it.write_data & DATA_KEEP;
        res.status = fee_pkg::ST_OK;
        res.read_data = '0;
        case (it.cmd)
            fee_pkg::CMD_WRITE: begin
                if (k == m) begin
                    res.status = fee_pkg::ST_ERASED_KEY;
                end else begin
                    if (page_fill >= fee_pkg::ENTRIES_PER_PAGE) compact_active_page();
                    if (page_fill >= fee_pkg::ENTRIES_PER_PAGE) begin
                        res.status = fee_pkg::ST_FULL;
                    end else begin
                        page_keys[page_fill] = k;
                        page_vals[page_fill] = d;
                        page_fill++;
                    end
                end
            end
            fee_pkg::CMD_READ: begin
                if (k == m) begin
                    res.status = fee_pkg::ST_ERASED_KEY;
                end else begin
                    res.status = fee_pkg::ST_NOT_FOUND;
                    found = 1'b0;
                    for (int i = page_fill; i > 0 && !found; i--) begin
                        if ((page_keys[i-1] & m) == k) begin
                            found = 1'b1;
                            res.status = fee_pkg::ST_OK;
                            res.read_data = page_vals[i-1];
                        end
                    end
                end
            end
            fee_pkg::CMD_ERASE: begin
                page_fill = 0;
            end
            default: begin
            end
        endcase
        status_seen[res.status]++;
        return res;
    endfunction

    // Appends one item to the backlog and tracks which keys the store holds,
    // so that random sessions can avoid filling it with distinct keys.
    function automatic void push_item(input logic [1:0] cmd, input logic [31:0] key,
                                      input logic [31:0] data);
        fee_pkg::t_in_item it;
        it.cmd = cmd;
        it.key = key;
        it.write_data = data;
        cmd_backlog.push_back(it);
        queued_items++;
        if (cmd == fee_pkg::CMD_ERASE) begin
            live_keys.delete();
        end else if (cmd == fee_pkg::CMD_WRITE && (key & gen_mask) != gen_mask) begin
            live_keys[key & gen_mask] = 1'b1;
        end
    endfunction

    // Keys mostly come from a small pool, with random bits above the key
    // width; a few are the erased marker or wholly random.
    function automatic logic [31:0] pick_key(input int base, input int size);
        int          r;
        logic [31:0] low;
        r = $urandom_range(99);
        if (r < 3) return $urandom() | gen_mask;
        if (r < 6) return $urandom();
        low = 32'(base + $urandom_range(size - 1)) & gen_mask;
        if (low == gen_mask) low = low & ~32'd1;
        return ($urandom() & ~gen_mask) | low;
    endfunction

    // A session of mixed writes and reads over one key pool. Writes that
    // would push the store towards 64 distinct keys get an erase first,
    // which keeps the costly store-full path for the dedicated fill runs.
    task automatic queue_session(input int count);
        int          pool_base;
        int          pool_size;
        int          r;
        logic [31:0] k;
        pool_size = $urandom_range(24, 3);
        pool_base = $urandom_range(200, 0);
        if ($urandom_range(1) == 0) push_item(fee_pkg::CMD_ERASE, $urandom(), $urandom());
        for (int n = 0; n < count; n++) begin
            r = $urandom_range(99);
            k = pick_key(pool_base, pool_size);
            if (r < 55) begin
                if (live_keys.num() >= 48 && !live_keys.exists(k & gen_mask)) begin
                    push_item(fee_pkg::CMD_ERASE, $urandom(), $urandom());
                end
                push_item(fee_pkg::CMD_WRITE, k, $urandom());
            end else if (r < 96) begin
                push_item(fee_pkg::CMD_READ, k, $urandom());
            end else if (r < 98) begin
                push_item(CMD_UNUSED, $urandom(), $urandom());
            end else begin
                push_item(fee_pkg::CMD_ERASE, $urandom(), $urandom());
            end
        end
    endtask

    // Fills the active page with 64 distinct keys, so that the next writes
    // compact without freeing anything and are dropped as store full.
    task automatic queue_fill_run();
        int          base;
        logic [31:0] upper;
        push_item(fee_pkg::CMD_ERASE, $urandom(), $urandom());
        base = $urandom_range(150, 0);
        for (int i = 0; i < fee_pkg::ENTRIES_PER_PAGE + 3; i++) begin
            upper = $urandom() & ~gen_mask;
            push_item(fee_pkg::CMD_WRITE, upper | (32'(base + i) & gen_mask), $urandom());
        end
        for (int i = 0; i < 6; i++) begin
            upper = $urandom() & ~gen_mask;
            push_item(fee_pkg::CMD_READ,
                      upper | (32'(base + $urandom_range(63)) & gen_mask), $urandom());
        end
        // The first dropped key must be absent.
        push_item(fee_pkg::CMD_READ, 32'(base + fee_pkg::ENTRIES_PER_PAGE), $urandom());
        // Rewriting a stored key is refused too, since nothing can be freed.
        push_item(fee_pkg::CMD_WRITE, 32'(base + 5), $urandom());
        push_item(fee_pkg::CMD_READ, 32'(base + 5), $urandom());
        push_item(fee_pkg::CMD_ERASE, $urandom(), $urandom());
    endtask

    // The block is idle once nothing is waiting, offered, owed or presented.
    // Sampling at the falling edge keeps the check clear of the clocked
    // processes that change these signals at the rising edge.
    task automatic wait_for_drain();
        @(negedge i_clk);
        while (cmd_backlog.size() != 0 || i_in_valid || expected_responses.size() != 0
               || o_out_valid) begin
            @(negedge i_clk);
        end
    endtask

    // Programs the key width. The prediction follows right away, which is
    // safe because the block is idle whenever this runs.
    task automatic write_key_bytes(input logic [fee_pkg::KEY_BYTES_W-1:0] kb);
        @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_wdata <= kb;
        model_key_bytes = kb;
        gen_mask = key_field_mask(kb);
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    // Driver. An item offered by valid stays on the port until the block
    // takes it; at the edge that takes it the expected response is formed,
    // and the next item may follow at once or after a random gap.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else begin
            if (i_in_valid && o_in_ready) begin
                expected_responses.push_back(predict_store_response(i_in_item));
                items_accepted++;
            end
            if (!i_in_valid || o_in_ready) begin
                if (cmd_backlog.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                    i_in_item <= cmd_backlog.pop_front();
                    i_in_valid <= 1'b1;
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    // Monitor. Each response taken from the block is matched field by field
    // against the oldest expectation. Ready is redrawn on every cycle.
    always @(posedge i_clk) begin
        fee_pkg::t_out_item want;
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
        end else begin
            if (o_out_valid && i_out_ready) begin
                if (expected_responses.size() == 0) begin
                    failures++;
                    $error("response with none expected");
                end else begin
                    want = expected_responses.pop_front();
                    if (o_out_item.status !== want.status) begin
                        failures++;
                        $error("status: expected %0d, actual %0d",
                               want.status, o_out_item.status);
                    end
                    if (o_out_item.read_data !== want.read_data) begin
                        failures++;
                        $error("read_data: expected %08h, actual %08h",
                               want.read_data, o_out_item.read_data);
                    end
                end
            end
            i_out_ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // Sequence of the run: reset, a directed part at the reset key width,
    // then phases of random sessions, each under a new key width that is
    // programmed while entries may still be stored.
    initial begin
        logic [fee_pkg::KEY_BYTES_W-1:0] phase_kb [NUM_PHASES];
        int                              phase_start;
        phase_kb = '{3'd1, 3'd4, 3'd0, 3'd7, 3'd3, 3'd2, 3'd5, 3'd6, 3'd1};

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        send_idle_pct = 37;
        recv_idle_pct = 59;
        write_key_bytes(fee_pkg::KEY_BYTES_TWO);

        // Directed part at a two byte key width.
        push_item(fee_pkg::CMD_READ, 32'h0000_0005, 32'h0);            // empty store
        push_item(fee_pkg::CMD_WRITE, 32'h0000_0000, 32'h0000_0000);
        push_item(fee_pkg::CMD_WRITE, 32'h0000_FFFE, 32'hFFFF_FFFF);    // largest usable key
        push_item(fee_pkg::CMD_WRITE, 32'hABCD_0001, 32'h1234_5678);    // upper bits ignored
        push_item(fee_pkg::CMD_READ, 32'h0000_0000, $urandom());
        push_item(fee_pkg::CMD_READ, 32'h0000_0001, 32'h0);
        push_item(fee_pkg::CMD_READ, 32'hFFFF_FFFE, 32'h0);
        push_item(fee_pkg::CMD_WRITE, 32'h5555_0001, 32'hA5A5_A5A5);    // newer copy of a key
        push_item(fee_pkg::CMD_READ, 32'h0000_0001, 32'h0);
        push_item(fee_pkg::CMD_WRITE, 32'h0000_FFFF, 32'h0BAD_F00D);    // erased marker key
        push_item(fee_pkg::CMD_READ, 32'h1234_FFFF, 32'h0);
        push_item(fee_pkg::CMD_WRITE, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        push_item(fee_pkg::CMD_READ, 32'h0000_0002, 32'h0);             // never written
        push_item(CMD_UNUSED, $urandom(), $urandom());
        push_item(CMD_UNUSED, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        push_item(fee_pkg::CMD_READ, 32'h0000_0000, 32'h0);             // untouched by it
        push_item(fee_pkg::CMD_ERASE, $urandom(), $urandom());
        push_item(fee_pkg::CMD_READ, 32'h0000_0000, 32'h0);             // gone after erase
        push_item(fee_pkg::CMD_READ, 32'h0000_FFFE, 32'h0);

        // Three idling regimes, three phases each: sender sparse and receiver
        // slow, then the other way round, then both at full rate.
        for (int p = 0; p < NUM_PHASES; p++) begin
            wait_for_drain();
            repeat (4) @(posedge i_clk);
            write_key_bytes(phase_kb[p]);
            case (p / 3)
                0: begin
                    send_idle_pct = 37;
                    recv_idle_pct = 59;
                end
                1: begin
                    send_idle_pct = 59;
                    recv_idle_pct = 37;
                end
                default: begin
                    send_idle_pct = 0;
                    recv_idle_pct = 0;
                end
            endcase
            phase_start = queued_items;
            if (p % 3 == 0) queue_fill_run();
            while (queued_items < phase_start + 170) queue_session($urandom_range(90, 30));
        end

        wait_for_drain();
        repeat (200) @(posedge i_clk);
        if (expected_responses.size() != 0) begin
            failures++;
            $error("%0d responses never arrived", expected_responses.size());
        end

        $display("Covered %0d items over %0d key width settings, %0d page compactions.",
                 items_accepted, NUM_PHASES + 1, compactions);
        $display("Responses: %0d ok, %0d not found, %0d store full, %0d erased key.",
                 status_seen[fee_pkg::ST_OK], status_seen[fee_pkg::ST_NOT_FOUND],
                 status_seen[fee_pkg::ST_FULL], status_seen[fee_pkg::ST_ERASED_KEY]);
        if (failures == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

    // Watchdog well beyond the slowest legal run.
    initial begin
        #500_000_000;
        $display("Verification failed");
        $finish;
    end

endmodule
